>>> hw/rtl/hkt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_pkg
// Shared types and constants for the hashed key table.
// ----------------------------------------------------------------------------
package hkt_pkg;

  localparam int unsigned SLOTS_DEF = 256;
  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
  localparam logic [8:0] LOAD_LIMIT_RST = 9'd192;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2
  } req_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic hash_step;
    logic probe_start;
    logic probe_adv;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic last;
    logic req_probe;
    logic stop;
  } dp_stat_t;

endpackage

>>> hw/rtl/hkt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_ctrl
// Sequencer: clearing pass, byte hashing, probe walk and result.
// ----------------------------------------------------------------------------
module hkt_ctrl
  import hkt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (!stat.last) state_next = S_IDLE;
        else            state_next = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        if (!stat.req_probe) state_next = S_FINISH;
        else begin
          cmd.probe_start = 1'b1;
          state_next = S_PROBE_CHK;
        end
      end
      S_PROBE_CHK: begin
        if (stat.stop) state_next = S_FINISH;
        else begin
          cmd.probe_adv = 1'b1;
          state_next = S_PROBE_CHK;
        end
      end
      S_FINISH: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/hkt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkt_dpath
// FNV-1a hash register, slot memories, probe walker and result register.
// ----------------------------------------------------------------------------
module hkt_dpath
  import hkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  req_type,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic [63:0] entry_value,
  input  logic [8:0]  load_limit,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] found_value
);

  localparam int unsigned SLOTS = SLOTS_DEF;
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // slot stores
  logic [63:0] hash_mem [SLOTS];
  logic [63:0] val_mem  [SLOTS];
  logic [1:0]  mark_mem [SLOTS];

  logic [1:0]  req_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [63:0] val_q;
  logic [63:0] run_hash;
  logic [63:0] key_hash;
  logic [63:0] mix;
  logic [63:0] prod;
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] idx;
  logic [CW-1:0] visited;
  logic [8:0]  used_count;
  logic        tomb_seen;
  logic [AW-1:0] tomb_idx;
  logic        hit;
  logic        free_ok;
  logic [AW-1:0] hit_idx;
  logic        full_early;
  logic        ins_ok;
  logic        probing;
  logic [1:0]  rd_mark;
  logic [63:0] rd_hash;
  logic        chk_valid;
  logic [AW-1:0] rd_idx;
  logic [1:0]  res_status;

  // multiply by the FNV prime (2^40 + 0x1B3) as shifts and adds
  assign mix  = run_hash ^ {56'd0, byte_q};
  assign prod = (mix << 40) + (mix << 8) + (mix << 7) + (mix << 5) +
                (mix << 4) + (mix << 1) + mix;
  assign full_early = ({1'b0, used_count} + 10'd1) > {1'b0, load_limit};

  // capture input byte and run the hash
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      byte_q <= key_byte;
      last_q <= key_last;
      val_q  <= entry_value;
    end
    if (rst) run_hash <= FNV_BASIS;
    else if (cmd.hash_step) begin
      if (last_q) run_hash <= FNV_BASIS;
      else        run_hash <= prod;
      key_hash <= prod;
    end
  end

  assign stat.last = last_q;
  assign stat.req_probe = (req_q == REQ_LOOKUP) || (req_q == REQ_DELETE) ||
                          ((req_q == REQ_INSERT) && !full_early);

  // clearing pass over the marks
  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
  end
  assign stat.clr_done = (clr_idx == AW'(SLOTS - 1));

  // registered memory read at the probe address
  always_ff @(posedge clk) begin
    rd_mark <= mark_mem[idx];
    rd_hash <= hash_mem[idx];
    rd_idx  <= idx;
  end

  // probe walker: a read issues, next cycle the slot is checked
  always_ff @(posedge clk) begin
    if (rst) begin
      probing <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= cmd.probe_adv && !chk_valid;
      if (cmd.probe_start) begin
        idx <= key_hash[AW-1:0];
        visited <= '0;
        tomb_seen <= 1'b0;
        hit <= 1'b0;
        free_ok <= 1'b0;
        probing <= 1'b1;
      end else if (cmd.probe_adv && chk_valid) begin
        visited <= visited + 1'b1;
        if (rd_mark == MARK_EMPTY) begin
          free_ok <= 1'b1;
          hit_idx <= tomb_seen ? tomb_idx : rd_idx;
          probing <= 1'b0;
        end else if (rd_mark == MARK_USED && rd_hash == key_hash) begin
          hit <= 1'b1;
          hit_idx <= rd_idx;
          probing <= 1'b0;
        end else begin
          if (rd_mark != MARK_USED && !tomb_seen) begin
            tomb_seen <= 1'b1;
            tomb_idx <= rd_idx;
          end
          if (visited == CW'(SLOTS - 1)) begin
            probing <= 1'b0;
            free_ok <= tomb_seen || (rd_mark != MARK_USED);
            hit_idx <= tomb_seen ? tomb_idx : rd_idx;
          end
          idx <= idx + 1'b1;
        end
      end
    end
  end

  assign stat.stop = !probing && !cmd.probe_start;

  assign ins_ok = !full_early && (hit || free_ok);

  // commit writes
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mark_mem[clr_idx] <= MARK_EMPTY;
    if (cmd.commit) begin
      if (req_q == REQ_INSERT && ins_ok) begin
        val_mem[hit_idx] <= val_q;
        if (!hit) begin
          mark_mem[hit_idx] <= MARK_USED;
          hash_mem[hit_idx] <= key_hash;
        end
      end else if (req_q == REQ_DELETE && hit) begin
        mark_mem[hit_idx] <= MARK_TOMB;
      end
    end
  end

  // pick the result status
  always_comb begin
    res_status = ST_MISSING;
    case (req_q)
      REQ_INSERT: res_status = ins_ok ? ST_OK : ST_FULL;
      REQ_LOOKUP: res_status = hit ? ST_OK : ST_MISSING;
      REQ_DELETE: res_status = hit ? ST_OK : ST_MISSING;
      default:    res_status = ST_MISSING;
    endcase
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        status <= res_status;
        found_value <= (req_q == REQ_LOOKUP && hit) ? val_mem[hit_idx] : 64'd0;
        if (req_q == REQ_INSERT && ins_ok && !hit) begin
          used_count <= used_count + 9'd1;
        end else if (req_q == REQ_DELETE && hit && used_count != 9'd0) begin
          used_count <= used_count - 9'd1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/hashed_key_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_key_table_unit
// Open-addressing hash table keyed by FNV-1a 64-bit hash of byte strings.
// ----------------------------------------------------------------------------
// channel   handshake             fields
// request   start / busy          req_type key_byte key_last entry_value
// result    done strobe           status found_value
// config    load_limit_we         load_limit_wdata
//
// A key byte with key_last low passes through capture and hash.
// A last byte is captured and hashed, then walks the slots (one memory read
// and one check per slot) before the finish; a full insert rejection or an
// unknown request skips the probe. The result strobe follows in the next cycle.
// After reset a clearing pass over all SLOTS_DEF slots holds busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
module hashed_key_table_unit
  import hkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic [63:0] entry_value,
  input  logic        load_limit_we,
  input  logic [8:0]  load_limit_wdata,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] found_value
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [8:0] load_limit;

  // hold the load limit register
  always_ff @(posedge clk) begin
    if (rst) load_limit <= LOAD_LIMIT_RST;
    else if (load_limit_we) load_limit <= load_limit_wdata;
  end

  hkt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  hkt_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .key_byte   (key_byte),
    .key_last   (key_last),
    .entry_value(entry_value),
    .load_limit (load_limit),
    .done       (done),
    .status     (status),
    .found_value(found_value)
  );

  // a result transfer only follows a commit
  assert property (@(posedge clk) disable iff (rst) done |-> $past(cmd.commit))
    else $error("result without commit");
  // no request is taken while a commit is under way
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> busy)
    else $error("commit while idle");
  // found value is zero unless the status is OK
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (found_value == 64'd0))
    else $error("non-zero value on failure");

endmodule
